>>> sv/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro expects clk and rst to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/irfe_pkg.sv
// ----------------------------------------------------------------------------
// irfe_pkg
// Types, codes and constants shared by the IR frame emitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package irfe_pkg;

  // Input word opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Carrier selection codes
  localparam logic CARRIER_455K = 1'b0;
  localparam logic CARRIER_57K  = 1'b1;

  // Emission port bits that survive a tick
  localparam logic [15:0] PORT_MASK = 16'h00C6;

  // Timer settings per carrier
  localparam logic [12:0] BIT_PERIOD_455K  = 13'd4000;
  localparam logic [12:0] BIT_PERIOD_57K   = 13'd5733;
  localparam logic [9:0]  CAR_PERIOD_455K  = 10'd89;
  localparam logic [9:0]  CAR_PERIOD_57K   = 10'd710;
  localparam logic [8:0]  CAR_COMPARE_455K = 9'd44;
  localparam logic [8:0]  CAR_COMPARE_57K  = 9'd355;

  // Power remap breakpoints for the 57.6 kHz carrier
  localparam logic [7:0] PWR_KNEE_LO  = 8'd100;
  localparam logic [7:0] PWR_KNEE_MID = 8'd175;
  localparam logic [7:0] PWR_KNEE_HI  = 8'd218;
  localparam logic [9:0] PWR_OFS_LIN  = 10'd200;
  localparam logic [9:0] PWR_OFS_STEP = 10'd127;
  localparam logic [7:0] PWR_MAX      = 8'd200;

  // Per-tick result produced by the control unit, before the store word is merged
  typedef struct packed {
    logic [15:0] port_masked;
    logic        use_mem;
    logic        carrier;
    logic        pot_write;
    logic [7:0]  pot_value;
    logic        taken;
  } tick_res_t;

  // Remap the nominal power for the 57.6 kHz carrier
  function automatic logic [7:0] remap_power(input logic [7:0] p);
    logic [9:0] p_ext;
    logic [9:0] lin;
    logic [9:0] step;
    p_ext = {2'b00, p};
    lin   = (p_ext << 1) - PWR_OFS_LIN;
    step  = ((p_ext + (p_ext << 1)) >> 1) - PWR_OFS_STEP;
    if (p <= PWR_KNEE_LO) begin
      remap_power = 8'd0;
    end else if (p <= PWR_KNEE_MID) begin
      remap_power = lin[7:0];
    end else if (p <= PWR_KNEE_HI) begin
      remap_power = step[7:0];
    end else begin
      remap_power = PWR_MAX;
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/irfe_ram.sv
// ----------------------------------------------------------------------------
// irfe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module irfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/irfe_ctrl.sv
// ----------------------------------------------------------------------------
// irfe_ctrl
// Per-tick sequencing: pause count, frame position, carrier switch and power.
// ----------------------------------------------------------------------------
`default_nettype none

module irfe_ctrl import irfe_pkg::*; #(
  parameter int FRAME_WORDS = 32,
  localparam int POS_W = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             tick_fire,
  input  wire logic [15:0]      port_in,
  input  wire logic             frame_offered,
  input  wire logic             cfg_fire,
  input  wire logic [7:0]       cfg_data,
  output tick_res_t             res,
  output logic      [POS_W-1:0] rd_addr
);

  logic [POS_W-1:0] word_pos;
  logic [POS_W-1:0] word_pos_next;
  logic             sending;
  logic             sending_next;
  logic             in_pause;
  logic             in_pause_next;
  logic             switch_pending;
  logic             switch_pending_next;
  logic             carrier_now;
  logic             carrier_next;
  logic [7:0]       nominal_power;
  logic             last_pos;
  logic             send_now;

  assign last_pos = (word_pos == POS_W'(FRAME_WORDS - 1));
  assign rd_addr  = word_pos;

  // Decide what this tick does
  always_comb begin
    word_pos_next       = word_pos;
    sending_next        = sending;
    in_pause_next       = in_pause;
    switch_pending_next = switch_pending;
    carrier_next        = carrier_now;
    send_now            = 1'b0;
    res.port_masked     = port_in & PORT_MASK;
    res.use_mem         = 1'b0;
    res.pot_write       = 1'b0;
    res.pot_value       = 8'd0;
    res.taken           = 1'b0;

    if (in_pause) begin
      // Drive zero for one frame length
      res.port_masked = 16'd0;
      if (last_pos) begin
        word_pos_next = '0;
        in_pause_next = 1'b0;
      end else begin
        word_pos_next = word_pos + 1'b1;
      end
    end else begin
      send_now = sending;
      // Switch carrier after a finished frame and arm the pause
      if (switch_pending) begin
        switch_pending_next = 1'b0;
        res.pot_write       = 1'b1;
        if (carrier_now == CARRIER_455K) begin
          res.pot_value = remap_power(nominal_power);
          carrier_next  = CARRIER_57K;
        end else begin
          res.pot_value = nominal_power;
          carrier_next  = CARRIER_455K;
          send_now      = 1'b0;
        end
        in_pause_next = 1'b1;
      end
      sending_next = send_now;
      if (send_now) begin
        // Emit the stored word at the current position
        res.use_mem = 1'b1;
        if (last_pos) begin
          word_pos_next       = '0;
          sending_next        = 1'b0;
          switch_pending_next = 1'b1;
        end else begin
          word_pos_next = word_pos + 1'b1;
        end
      end else if (frame_offered) begin
        sending_next = 1'b1;
        res.taken    = 1'b1;
      end
    end
    res.carrier = carrier_next;
  end

  // Advance state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      word_pos       <= '0;
      sending        <= 1'b0;
      in_pause       <= 1'b0;
      switch_pending <= 1'b0;
      carrier_now    <= CARRIER_455K;
    end else if (tick_fire) begin
      word_pos       <= word_pos_next;
      sending        <= sending_next;
      in_pause       <= in_pause_next;
      switch_pending <= switch_pending_next;
      carrier_now    <= carrier_next;
    end
  end

  // Hold the power register
  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_power <= 8'd0;
    end else if (cfg_fire) begin
      nominal_power <= cfg_data;
    end
  end

endmodule

`default_nettype wire

>>> sv/dual_carrier_ir_frame_emitter.sv
// ----------------------------------------------------------------------------
// dual_carrier_ir_frame_emitter
// Tick-driven IR frame emitter alternating between two carrier settings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word per handshake. op selects
//   a store load (word_index, word_value) or a bit tick (port_in,
//   frame_offered). A load gives no result; every tick gives one result word
//   on the output channel (out_valid/out_ready).
//   Config channel (cfg_valid/cfg_data) writes the nominal power register;
//   cfg_ready is always high. Write it only while the emitter is idle.
//   A tick's result is registered in the frame store read stage and then in
//   the output register before it shows on out_valid.
//   Throughput: one word per cycle while out_ready is high; the frame store
//   read port is used once per tick and the write port once per in-range load.
//   Stall: a held result and one tick in the read stage can wait together;
//   in_ready drops only when both are full and out_ready is low.
//   Reset: rst clears position, pause, switch and carrier state (455 kHz) and
//   the nominal power; the frame store is not cleared and must be loaded
//   before use.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_carrier_ir_frame_emitter import irfe_pkg::*; #(
  parameter int FRAME_WORDS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [15:0] port_in,
  input  wire logic        frame_offered,
  input  wire logic [4:0]  word_index,
  input  wire logic [15:0] word_value,
  // config channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      port_out,
  output logic             carrier_sel,
  output logic [12:0]      bit_period,
  output logic [9:0]       carrier_period,
  output logic [8:0]       carrier_compare,
  output logic             pot_write,
  output logic [7:0]       pot_value,
  output logic             frame_taken
);

  localparam int POS_W = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;

  logic             in_fire;
  logic             tick_fire;
  logic             load_fire;
  logic             cfg_fire;
  logic             load_in_range;
  logic [8:0]       widx_ext;
  logic [POS_W-1:0] wr_addr;
  logic [POS_W-1:0] rd_addr;
  logic [15:0]      rd_data;
  tick_res_t        tick_res;
  logic             s1_valid;
  tick_res_t        s1_res;
  logic             s1_move;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  // Handshake: the read stage moves on when the output register frees up
  assign s1_move   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || s1_move;
  assign in_fire   = in_valid & in_ready;
  assign tick_fire = in_fire & (op == OP_TICK);
  assign load_fire = in_fire & (op == OP_LOAD);

  // Drop loads beyond the frame length
  assign widx_ext      = 9'(word_index);
  assign load_in_range = (32'(word_index) < FRAME_WORDS);
  assign wr_addr       = widx_ext[POS_W-1:0];

  irfe_ctrl #(
    .FRAME_WORDS(FRAME_WORDS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .tick_fire    (tick_fire),
    .port_in      (port_in),
    .frame_offered(frame_offered),
    .cfg_fire     (cfg_fire),
    .cfg_data     (cfg_data),
    .res          (tick_res),
    .rd_addr      (rd_addr)
  );

  irfe_ram #(
    .WIDTH(16),
    .DEPTH(FRAME_WORDS)
  ) u_store (
    .clk    (clk),
    .wr_en  (load_fire & load_in_range),
    .wr_addr(wr_addr),
    .wr_data(word_value),
    .rd_en  (tick_fire),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Read stage: hold the tick result while the store word comes back
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= tick_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      s1_res <= tick_res;
    end
  end

  // Output register: merge the store word into the port value
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      port_out    <= s1_res.port_masked | (s1_res.use_mem ? rd_data : 16'd0);
      carrier_sel <= s1_res.carrier;
      pot_write   <= s1_res.pot_write;
      pot_value   <= s1_res.pot_value;
      frame_taken <= s1_res.taken;
    end
  end

  // Decode timer settings from the carrier
  assign bit_period      = (carrier_sel == CARRIER_57K) ? BIT_PERIOD_57K  : BIT_PERIOD_455K;
  assign carrier_period  = (carrier_sel == CARRIER_57K) ? CAR_PERIOD_57K  : CAR_PERIOD_455K;
  assign carrier_compare = (carrier_sel == CARRIER_57K) ? CAR_COMPARE_57K : CAR_COMPARE_455K;

endmodule

`default_nettype wire

>>> sv/irfe_chk.sv
// ----------------------------------------------------------------------------
// irfe_chk
// Port-level checks on the emitter's result words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module irfe_chk import irfe_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] port_out,
  input wire logic        carrier_sel,
  input wire logic [12:0] bit_period,
  input wire logic        pot_write,
  input wire logic [7:0]  pot_value,
  input wire logic        frame_taken
);

  // A stalled result word stays put
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(port_out))

  // No power value without a potentiometer write
  `ASSERT_IMPL(a_pot_quiet, out_valid && !pot_write, pot_value == 8'd0)

  // A tick that takes a frame emits only the masked port bits
  `ASSERT_IMPL(a_take_masked, out_valid && frame_taken, (port_out & ~PORT_MASK) == 16'd0)

  // Bit period follows the reported carrier
  `ASSERT_IMPL(a_period_match, out_valid, (carrier_sel == CARRIER_57K) ? (bit_period == BIT_PERIOD_57K) : (bit_period == BIT_PERIOD_455K))

endmodule

bind dual_carrier_ir_frame_emitter irfe_chk u_irfe_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .port_out   (port_out),
  .carrier_sel(carrier_sel),
  .bit_period (bit_period),
  .pot_write  (pot_write),
  .pot_value  (pot_value),
  .frame_taken(frame_taken)
);

`default_nettype wire

>>> sim/dual_carrier_ir_frame_emitter_test.sv
// ----------------------------------------------------------------------------
// dual_carrier_ir_frame_emitter_test
// Self-checking bench for the dual-carrier IR frame emitter. A behavioral
// copy of the emitter state tracks every accepted word. Each tick queues one
// expected result word, and each result handed out by the block is checked
// field by field. Directed sequences cover idle ticks, taking a frame,
// loading under an active frame, and the carrier switch and pause. Random
// traffic phases then run under several power settings and different
// sender idle and receiver stall rates.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_carrier_ir_frame_emitter_test;
  import irfe_pkg::*;

  localparam int STORE_DEPTH = 32;

  // Expected result of one tick
  typedef struct packed {
    logic [15:0] port;
    logic        car;
    logic [12:0] bitp;
    logic [9:0]  carp;
    logic [8:0]  carc;
    logic        pw;
    logic [7:0]  pv;
    logic        taken;
  } tick_word_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        op;
  logic [15:0] port_in;
  logic        frame_offered;
  logic [4:0]  word_index;
  logic [15:0] word_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] port_out;
  logic        carrier_sel;
  logic [12:0] bit_period;
  logic [9:0]  carrier_period;
  logic [8:0]  carrier_compare;
  logic        pot_write;
  logic [7:0]  pot_value;
  logic        frame_taken;

  // Emitter state as predicted from the accepted words
  logic [15:0] em_store [STORE_DEPTH];
  int          em_pos;
  logic        em_sending;
  logic        em_pause;
  logic        em_switch;
  logic        em_carrier;
  logic [7:0]  em_power;

  tick_word_t  expected_ticks [$];
  int          mismatch_count = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;

  dual_carrier_ir_frame_emitter #(
    .FRAME_WORDS(STORE_DEPTH)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .port_in        (port_in),
    .frame_offered  (frame_offered),
    .word_index     (word_index),
    .word_value     (word_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .port_out       (port_out),
    .carrier_sel    (carrier_sel),
    .bit_period     (bit_period),
    .carrier_period (carrier_period),
    .carrier_compare(carrier_compare),
    .pot_write      (pot_write),
    .pot_value      (pot_value),
    .frame_taken    (frame_taken)
  );

  // 4-unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Power sent to the potentiometer when moving to the 57.6 kHz carrier
  function automatic logic [7:0] power_at_57k(input logic [7:0] p);
    int v;
    v = p;
    if (v <= 100) return 8'd0;
    if (v <= 175) return 8'(2 * v - 200);
    if (v <= 218) return 8'(((3 * v) >> 1) - 127);
    return 8'd200;
  endfunction

  // Advance the emitter by one tick and return the word it should emit
  function automatic tick_word_t step_emitter(input logic [15:0] port, input logic offered);
    tick_word_t w;
    w = '0;
    w.port = port & PORT_MASK;
    if (em_pause) begin
      // count out one frame length of silence
      em_pos++;
      if (em_pos >= STORE_DEPTH) begin
        em_pos = 0;
        em_pause = 1'b0;
      end
      w.port = '0;
    end else begin
      // flip carrier after a finished frame, then arm the pause
      if (em_switch) begin
        em_switch = 1'b0;
        w.pw = 1'b1;
        if (em_carrier == CARRIER_455K) begin
          w.pv = power_at_57k(em_power);
          em_carrier = CARRIER_57K;
        end else begin
          w.pv = em_power;
          em_carrier = CARRIER_455K;
          em_sending = 1'b0;
        end
        em_pause = 1'b1;
      end
      if (em_sending) begin
        w.port |= em_store[em_pos];
        em_pos++;
        if (em_pos >= STORE_DEPTH) begin
          em_pos = 0;
          em_sending = 1'b0;
          em_switch = 1'b1;
        end
      end else if (offered) begin
        em_sending = 1'b1;
        w.taken = 1'b1;
      end
    end
    w.car  = em_carrier;
    w.bitp = (em_carrier == CARRIER_57K) ? BIT_PERIOD_57K : BIT_PERIOD_455K;
    w.carp = (em_carrier == CARRIER_57K) ? CAR_PERIOD_57K : CAR_PERIOD_455K;
    w.carc = (em_carrier == CARRIER_57K) ? CAR_COMPARE_57K : CAR_COMPARE_455K;
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Check every result word against the oldest expectation
  always @(posedge clk) begin
    tick_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch("result word with no tick pending");
      end else begin
        w = expected_ticks.pop_front();
        check_field("port_out", port_out, w.port);
        check_field("carrier_sel", carrier_sel, w.car);
        check_field("bit_period", bit_period, w.bitp);
        check_field("carrier_period", carrier_period, w.carp);
        check_field("carrier_compare", carrier_compare, w.carc);
        check_field("pot_write", pot_write, w.pw);
        check_field("pot_value", pot_value, w.pv);
        check_field("frame_taken", frame_taken, w.taken);
      end
    end
  end

  // Stall the receiver at the current rate
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= sink_stall_pct);
  end

  // Send one word; called and returns at a falling edge
  task automatic send_word(input logic w_op, input logic [15:0] port, input logic offered,
                           input logic [4:0] idx, input logic [15:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    op            = w_op;
    port_in       = port;
    frame_offered = offered;
    word_index    = idx;
    word_value    = val;
    do @(posedge clk); while (!in_ready);
    if (w_op == OP_LOAD) begin
      if (idx < STORE_DEPTH) em_store[idx] = val;
    end else begin
      expected_ticks.push_back(step_emitter(port, offered));
    end
    @(negedge clk);
  endtask

  task automatic send_tick(input logic [15:0] port, input logic offered);
    send_word(OP_TICK, port, offered, 5'($urandom), 16'($urandom));
  endtask

  task automatic send_load(input logic [4:0] idx, input logic [15:0] val);
    send_word(OP_LOAD, 16'($urandom), 1'($urandom), idx, val);
  endtask

  // Drop valid and wait until every result is back, plus pipeline slack
  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_ticks.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_power(input logic [7:0] p);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data  = p;
    do @(posedge clk); while (!cfg_ready);
    em_power = p;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Fill every store entry before any frame can read it
  task automatic test_store_preload();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (i == 0) send_load(5'(i), 16'hFFFF);
      else if (i == 1) send_load(5'(i), 16'h0000);
      else send_load(5'(i), 16'($urandom));
    end
  endtask

  // Ticks with no frame offered leave the emitter idle
  task automatic test_idle_ticks();
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'h0000, 1'b0);
    send_tick(16'hFF39, 1'b0);
  endtask

  // Take a frame, then load ahead of and behind the current position
  task automatic test_take_and_load();
    send_tick(16'h0000, 1'b1);
    send_tick(16'hFFFF, 1'b1);
    send_load(5'd2, 16'h5A5A);
    send_load(5'd0, 16'h1234);
    send_tick(16'h0000, 1'b0);
    send_tick(16'h00C6, 1'b1);
    send_load(5'd31, 16'hA5A5);
  endtask

  // Run through frame end, carrier switch with a frame offered, and pause
  task automatic test_switch_and_pause();
    write_power(8'd255);
    repeat (140) send_tick(16'($urandom), 1'b1);
    wait_idle();
  endtask

  task automatic random_item();
    if ($urandom_range(99) < 12) begin
      send_load(5'($urandom), 16'($urandom));
    end else begin
      send_tick(16'($urandom), $urandom_range(99) < 85);
    end
  endtask

  // Random traffic under several power settings and idle profiles
  task automatic test_random_traffic();
    logic [7:0] powers [10];
    powers = '{8'd0, 8'd100, 8'd101, 8'd175, 8'd176, 8'd218, 8'd219, 8'd255,
               8'($urandom), 8'($urandom)};
    for (int ph = 0; ph < 10; ph++) begin
      write_power(powers[ph]);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 70; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 70; end
        default: begin src_idle_pct = 29; sink_stall_pct = 29; end
      endcase
      repeat (137) random_item();
    end
    src_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    op            = OP_TICK;
    port_in       = '0;
    frame_offered = 1'b0;
    word_index    = '0;
    word_value    = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    out_ready     = 1'b1;
    // predicted state after reset
    foreach (em_store[i]) em_store[i] = '0;
    em_pos     = 0;
    em_sending = 1'b0;
    em_pause   = 1'b0;
    em_switch  = 1'b0;
    em_carrier = CARRIER_455K;
    em_power   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_store_preload();
    test_idle_ticks();
    test_take_and_load();
    test_switch_and_pause();
    test_random_traffic();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
